// File: src/bsb_pkg.sv
package bsb_pkg;
   localparam int KnotDepth = 64;
   localparam int MaxOrder = 8;
   localparam int KIdxW = $clog2(KnotDepth);
   localparam int OrdW = 4;
   localparam int NodeW = $clog2(MaxOrder + 1);
   localparam logic [16:0] OneQ16 = 17'd65536;
   localparam logic OpWrite = 1'b0;
   localparam logic OpEval = 1'b1;

   typedef struct packed {
      logic       load_knot;
      logic       rd_knot;
      logic [NodeW-1:0] rd_slot;
      logic       init_nodes;
      logic       start_term;
      logic       second_term;
      logic [NodeW-1:0] j;
      logic [NodeW-1:0] r;
      logic       mul_step;
      logic       div_start;
      logic       store_node;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;
endpackage

// File: src/bsb_if.sv
interface bsb_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [5:0]  knot_index;
   logic signed [31:0] knot_value;
   logic [5:0]  interval;
   logic [3:0]  order;
   logic signed [31:0] mu;
   modport source(output valid, operation, knot_index, knot_value, interval, order, mu,
                  input ready);
   modport sink(input valid, operation, knot_index, knot_value, interval, order, mu,
                output ready);
endinterface

interface bsb_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] basis_value;
   logic        out_of_range;
   modport source(output valid, basis_value, out_of_range, input ready);
   modport sink(input valid, basis_value, out_of_range, output ready);
endinterface

// File: src/bsb_datapath.sv
module bsb_datapath
   import bsb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [KIdxW-1:0]  wr_idx,
   input  logic signed [31:0] wr_val,
   input  logic              wr_en,
   input  logic [KIdxW-1:0]  rd_idx,
   input  logic signed [31:0] mu,
   output logic [16:0]       result
);
   logic signed [31:0] mem [KnotDepth];
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] t_ff [MaxOrder+1];
   logic [16:0] nv_ff [MaxOrder+1];
   logic signed [32:0] num_ff, den_ff;
   logic [16:0] val_ff;
   logic signed [50:0] prod_ff;
   // divider state: magnitudes
   logic [50:0] quo_ff, quo_in;
   logic [50:0] rem_ff, rem_in;
   logic [32:0] dmag_ff;
   logic neg_ff;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff;
   logic signed [52:0] acc_ff;
   logic [NodeW-1:0] jr, jr1;
   logic [NodeW:0] jrr;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_val;
      if (cmd.rd_knot) rd_data_ff <= mem[rd_idx];
   end

   assign jrr = {1'b0, cmd.j} + {1'b0, cmd.r};
   assign jr = jrr[NodeW-1:0];
   assign jr1 = jr - NodeW'(1);

   always_comb begin
      logic [51:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[50]} - {19'd0, dmag_ff};
      if (busy_ff) begin
         if (!trial[51]) begin
            rem_in = trial[50:0];
            quo_in = {quo_ff[49:0], 1'b1};
         end else begin
            rem_in = {rem_ff[49:0], quo_ff[50]};
            quo_in = {quo_ff[49:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         busy_ff <= (den_ff != 0);
      end else if (busy_ff && cnt_ff == 6'd1) begin
         busy_ff <= 1'b0;
      end
      if (cmd.load_knot) t_ff[cmd.rd_slot] <= rd_data_ff;
      if (cmd.init_nodes) begin
         for (int i = 0; i < MaxOrder; i++)
            nv_ff[i] <= (t_ff[i] <= mu && mu < t_ff[i+1]) ? OneQ16 : 17'd0;
         nv_ff[MaxOrder] <= 17'd0;
      end
      if (cmd.start_term) begin
         if (!cmd.second_term) begin
            num_ff <= 33'(mu) - 33'(t_ff[cmd.j]);
            den_ff <= 33'(t_ff[jr1]) - 33'(t_ff[cmd.j]);
            val_ff <= nv_ff[cmd.j];
            acc_ff <= '0;
         end else begin
            num_ff <= 33'(t_ff[jr]) - 33'(mu);
            den_ff <= 33'(t_ff[jr]) - 33'(t_ff[cmd.j + NodeW'(1)]);
            val_ff <= nv_ff[cmd.j + NodeW'(1)];
         end
      end
      if (cmd.mul_step) prod_ff <= num_ff * $signed({1'b0, val_ff});
      if (cmd.div_start) begin
         quo_ff <= prod_ff[50] ? 51'(-prod_ff) : 51'(prod_ff);
         rem_ff <= '0;
         dmag_ff <= den_ff[32] ? 33'(-den_ff) : 33'(den_ff);
         neg_ff <= prod_ff[50] ^ den_ff[32];
         cnt_ff <= 6'd51;
      end else begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
      if (sts.div_done && cmd.store_node) begin
         logic signed [52:0] q, s;
         q = (den_ff == 0) ? 53'sd0 : (neg_ff ? -$signed({2'b0, quo_ff}) :
                                                 $signed({2'b0, quo_ff}));
         s = acc_ff + q;
         if (!cmd.second_term) acc_ff <= s;
         else if (s < 0) nv_ff[cmd.j] <= 17'd0;
         else if (s > 53'sd65536) nv_ff[cmd.j] <= OneQ16;
         else nv_ff[cmd.j] <= s[16:0];
      end
   end

   assign sts.div_done = !busy_ff;
   assign result = nv_ff[0];
endmodule

// File: src/bsb_ctrl.sv
module bsb_ctrl
   import bsb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic [3:0] k,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       done,
   output logic [NodeW-1:0] rd_off
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_READ = 8'b00000010, S_LOAD = 8'b00000100,
      S_INIT = 8'b00001000, S_TERM = 8'b00010000, S_MUL = 8'b00100000,
      S_DIV = 8'b01000000, S_WAIT = 8'b10000000
   } state_type;
   state_type st_ff, st_in;
   logic [NodeW-1:0] i_ff, i_in, j_ff, j_in, r_ff, r_in;
   logic sec_ff, sec_in;
   logic [NodeW:0] jr;

   assign jr = {1'b0, j_ff} + {1'b0, r_ff};
   assign rd_off = i_ff;

   always_comb begin
      st_in = st_ff; i_in = i_ff; j_in = j_ff; r_in = r_ff; sec_in = sec_ff;
      cmd = '0;
      done = 1'b0;
      cmd.j = j_ff; cmd.r = r_ff; cmd.second_term = sec_ff; cmd.rd_slot = i_ff;
      unique case (st_ff)
         S_IDLE: if (go) begin st_in = S_READ; i_in = '0; end
         S_READ: begin cmd.rd_knot = 1'b1; st_in = S_LOAD; end
         S_LOAD: begin
            cmd.load_knot = 1'b1;
            if (i_ff == NodeW'(k)) st_in = S_INIT;
            else begin i_in = i_ff + NodeW'(1); st_in = S_READ; end
         end
         S_INIT: begin
            cmd.init_nodes = 1'b1;
            j_in = '0; r_in = NodeW'(2); sec_in = 1'b0;
            if (k < 4'd2) begin st_in = S_IDLE; done = 1'b1; end
            else st_in = S_TERM;
         end
         S_TERM: begin cmd.start_term = 1'b1; st_in = S_MUL; end
         S_MUL: begin cmd.mul_step = 1'b1; st_in = S_DIV; end
         S_DIV: begin cmd.div_start = 1'b1; st_in = S_WAIT; end
         S_WAIT: if (sts.div_done) begin
            cmd.store_node = 1'b1;
            st_in = S_TERM;
            if (!sec_ff) sec_in = 1'b1;
            else begin
               sec_in = 1'b0;
               if (jr + (NodeW+1)'(1) <= {1'b0, NodeW'(k)}) j_in = j_ff + NodeW'(1);
               else if ({1'b0, r_ff} == {1'b0, NodeW'(k)}) begin
                  st_in = S_IDLE; done = 1'b1;
               end else begin j_in = '0; r_in = r_ff + NodeW'(1); end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
      i_ff <= i_in; j_ff <= j_in; r_ff <= r_in; sec_ff <= sec_in;
   end
   assign busy = (st_ff != S_IDLE);

`ifndef SYNTHESIS
   a_order: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_WAIT |-> r_ff >= NodeW'(2)) else $error("bad order");
   a_node: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_WAIT |-> jr <= {1'b0, NodeW'(k)}) else $error("node past triangle");
   a_go: assert property (@(posedge clock) disable iff (reset)
      go |-> st_ff == S_IDLE) else $error("start while busy");
`endif
endmodule

// File: src/bspline_basis_eval.sv
// B-spline basis evaluator, Cox-de Boor recurrence.
// req channel: operation 0 writes knot_value at knot_index (no response);
// operation 1 evaluates N(interval, order) at mu and returns one rsp transfer
// carrying basis_value (Q1.16) and out_of_range.
// An evaluation loads order+1 knots, each through a read and a load state,
// then runs the triangle of order*(order-1)/2 nodes; each node takes two
// terms through the shared 51-bit restoring divider, which is skipped when
// the span is zero. One item at a time.
// Out-of-range evaluations answer in the cycle after the request with value 0.
// Reset clears control; the knot store holds garbage until written.
// When rsp is stalled the result waits in its output register and req.ready
// stays low until the transfer completes.
module bspline_basis_eval
   import bsb_pkg::*;
(
   input logic clock,
   input logic reset,
   bsb_req_if.sink   req,
   bsb_rsp_if.source rsp
);
   cmd_type cmd;
   sts_type sts;
   logic busy, done, go;
   logic [NodeW-1:0] rd_off;
   logic [KIdxW-1:0] base_ff;
   logic [3:0] k_ff, k_in;
   logic signed [31:0] mu_ff;
   logic [16:0] result;
   logic [6:0] span;
   logic rsp_valid_ff, oor_ff;
   logic [16:0] val_ff;
   logic go_ff;
   logic done_ff;

   assign req.ready = !busy && !rsp_valid_ff && !go_ff && !done_ff;
   assign k_in = (req.order == 4'd0) ? 4'd1 :
                 (req.order > 4'(MaxOrder)) ? 4'(MaxOrder) : req.order;
   assign span = {1'b0, req.interval} + {3'b0, k_in};

   // register the item so the datapath sees registered mu and base
   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.operation == OpEval) begin
         base_ff <= req.interval;
         k_ff <= k_in;
         mu_ff <= req.mu;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         go_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         go_ff <= 1'b0;
         // register done so the last node write has landed before the result is taken
         done_ff <= done;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (req.valid && req.ready && req.operation == OpEval) begin
            if (span > 7'(KnotDepth - 1)) begin
               rsp_valid_ff <= 1'b1; oor_ff <= 1'b1; val_ff <= '0;
            end else go_ff <= 1'b1;
         end
         if (done_ff) begin
            rsp_valid_ff <= 1'b1; oor_ff <= 1'b0; val_ff <= result;
         end
      end
   end
   assign go = go_ff;

   bsb_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .wr_idx(req.knot_index), .wr_val(req.knot_value),
      .wr_en(req.valid && req.ready && req.operation == OpWrite),
      .rd_idx(base_ff + KIdxW'(rd_off)), .mu(mu_ff), .result
   );

   bsb_ctrl u_ctrl (
      .clock, .reset, .go, .k(k_ff), .sts, .cmd, .busy, .done, .rd_off
   );

   assign rsp.valid = rsp_valid_ff;
   assign rsp.basis_value = val_ff;
   assign rsp.out_of_range = oor_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !rsp_valid_ff) else $error("result overrun");
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && oor_ff |-> val_ff == 17'd0) else $error("range flag with value");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> val_ff <= OneQ16) else $error("value above one");
`endif
endmodule
